### rtl/skf_pkg.sv
// Shared types, constants and the control store of the scalar Kalman filter.
package skf_pkg;

	localparam int SampleW = 12;
	localparam int EstW    = 28;
	localparam int VarW    = 32;
	localparam int GainW   = 31;
	localparam int DenW    = VarW + 1;
	localparam int RemW    = DenW + 1;
	localparam int ProdW   = GainW + VarW;
	localparam int FracW   = 30;
	localparam int CntW    = 5;
	localparam int CfgIdxW = 2;

	localparam logic [GainW-1:0] OneQ30    = GainW'(1) << FracW;
	localparam logic [CntW-1:0]  DivFirst  = CntW'(FracW);

	// Register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] RegProcessNoise     = 2'd0;
	localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 2'd1;
	localparam logic [CfgIdxW-1:0] RegInitialVariance  = 2'd2;
	localparam logic [CfgIdxW-1:0] RegInitialEstimate  = 2'd3;

	// Reset values of the configuration registers
	localparam logic [VarW-1:0] ProcessNoiseRst     = 32'd107374;
	localparam logic [VarW-1:0] MeasurementNoiseRst = 32'd268435456;
	localparam logic [VarW-1:0] InitialVarianceRst  = 32'd1073741824;
	localparam logic [EstW-1:0] InitialEstimateRst  = 28'd1310720;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ADDQ,
		OP_DEN,
		OP_DIV,
		OP_INV,
		OP_MUL_KS,
		OP_MUL_IX,
		OP_MUL_IP,
		OP_WB
	} dp_op_t;

	// Jump conditions of a control word
	typedef enum logic [1:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_LOOP
	} cond_t;

	// Handshake a step waits on before it executes
	typedef enum logic [1:0] {
		GATE_NONE,
		GATE_IN,
		GATE_OUT
	} gate_t;

	// Program steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADDQ,
		ST_DEN,
		ST_DIV,
		ST_INV,
		ST_MUL_KS,
		ST_MUL_IX,
		ST_MUL_IP,
		ST_WB
	} step_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		gate_t  gate;
		step_t  target;
	} ctrl_word_t;

	typedef struct packed {
		dp_op_t op;
		logic   fire;
	} dp_ctrl_t;

	typedef struct packed {
		logic            cnt_zero;
		logic [EstW-1:0] acc;
	} dp_stat_t;

	typedef struct packed {
		logic [VarW-1:0] process_noise;
		logic [VarW-1:0] measurement_noise;
		logic            load_p;
		logic [VarW-1:0] p_value;
		logic            load_x;
		logic [EstW-1:0] x_value;
	} dp_cfg_t;

	// Control store: one word per step
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: COND_NEXT, gate: GATE_NONE, target: ST_IDLE};
		case (step)
			ST_IDLE:   w = '{op: OP_LOAD,   cond: COND_NEXT,   gate: GATE_IN,   target: ST_IDLE};
			ST_ADDQ:   w = '{op: OP_ADDQ,   cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_DEN:    w = '{op: OP_DEN,    cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_DIV:    w = '{op: OP_DIV,    cond: COND_LOOP,   gate: GATE_NONE, target: ST_DIV};
			ST_INV:    w = '{op: OP_INV,    cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_MUL_KS: w = '{op: OP_MUL_KS, cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_MUL_IX: w = '{op: OP_MUL_IX, cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_MUL_IP: w = '{op: OP_MUL_IP, cond: COND_NEXT,   gate: GATE_NONE, target: ST_IDLE};
			ST_WB:     w = '{op: OP_WB,     cond: COND_ALWAYS, gate: GATE_OUT,  target: ST_IDLE};
			default:   w = '{op: OP_NOP,    cond: COND_ALWAYS, gate: GATE_NONE, target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

### rtl/skf_sample_if.sv
// Input channel carrying one ADC sample per item.
interface skf_sample_if;
	import skf_pkg::*;
	logic               valid;
	logic               ready;
	logic [SampleW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### rtl/skf_result_if.sv
// Output channel carrying one filtered estimate per item.
interface skf_result_if;
	import skf_pkg::*;
	logic               valid;
	logic               ready;
	logic [EstW-1:0]    estimate_fixed;
	logic [SampleW-1:0] estimate_whole;

	modport source (output valid, output estimate_fixed, output estimate_whole, input ready);
	modport sink (input valid, input estimate_fixed, input estimate_whole, output ready);
endinterface

### rtl/skf_datapath.sv
// Filter datapath: state, restoring divider and one shared multiplier.
module skf_datapath
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctrl_t           ctrl,
	input  dp_cfg_t            cfg,
	input  logic [SampleW-1:0] sample,
	output dp_stat_t           stat
);

	logic [VarW-1:0]    p_q;
	logic [EstW-1:0]    x_q;
	logic [SampleW-1:0] sample_q;
	logic [VarW-1:0]    p1_q;
	logic [DenW-1:0]    den_q;
	logic [RemW-1:0]    rem_q;
	logic [GainW-1:0]   quo_q;
	logic [CntW-1:0]    cnt_q;
	logic [GainW-1:0]   gain_q;
	logic [GainW-1:0]   inv_q;
	logic [ProdW-1:0]   prod_q;
	logic [EstW-1:0]    acc_q;

	logic [VarW:0]      p_sum;
	logic [VarW-1:0]    p1_next;
	logic               in_bit;
	logic [RemW-1:0]    trial;
	logic               fits;
	logic [GainW-1:0]   gain_next;
	logic [GainW-1:0]   mul_a;
	logic [VarW-1:0]    mul_b;
	logic [ProdW-1:0]   prod;
	logic [EstW:0]      acc_sum;

	// Saturating add of the process noise
	assign p_sum   = {1'b0, p_q} + {1'b0, cfg.process_noise};
	assign p1_next = p_sum[VarW] ? {VarW{1'b1}} : p_sum[VarW-1:0];

	// One restoring division step: the numerator is P1 shifted up by the fraction width
	assign in_bit = (cnt_q == DivFirst) ? p1_q[0] : 1'b0;
	assign trial  = {rem_q[RemW-2:0], in_bit};
	assign fits   = trial >= {1'b0, den_q};

	// Gain is zero when the denominator is zero
	assign gain_next = (den_q == '0) ? '0 : quo_q;

	// Shared multiplier operands
	always_comb begin
		mul_a = gain_q;
		mul_b = VarW'(sample_q);
		case (ctrl.op)
			OP_MUL_IX: begin
				mul_a = inv_q;
				mul_b = VarW'(x_q);
			end
			OP_MUL_IP: begin
				mul_a = inv_q;
				mul_b = p1_q;
			end
			default: begin
				mul_a = gain_q;
				mul_b = VarW'(sample_q);
			end
		endcase
	end

	assign prod    = ProdW'(mul_a) * ProdW'(mul_b);
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q[FracW+EstW-1:FracW]};

	// Filter state: preload from configuration, update on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= InitialVarianceRst;
			x_q <= InitialEstimateRst;
		end else begin
			if (cfg.load_p) begin
				p_q <= cfg.p_value;
			end else if (ctrl.fire && ctrl.op == OP_WB) begin
				p_q <= prod_q[FracW+VarW-1:FracW];
			end
			if (cfg.load_x) begin
				x_q <= cfg.x_value;
			end else if (ctrl.fire && ctrl.op == OP_WB) begin
				x_q <= acc_q;
			end
		end
	end

	// Division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.fire) begin
			case (ctrl.op)
				OP_DEN:  cnt_q <= DivFirst;
				OP_DIV:  cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.op)
				OP_LOAD: sample_q <= sample;
				OP_ADDQ: p1_q <= p1_next;
				OP_DEN: begin
					den_q <= {1'b0, p1_q} + {1'b0, cfg.measurement_noise};
					rem_q <= RemW'(p1_q[VarW-1:1]);
					quo_q <= '0;
				end
				OP_DIV: begin
					rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
					quo_q <= {quo_q[GainW-2:0], fits};
				end
				OP_INV: begin
					gain_q <= gain_next;
					inv_q  <= OneQ30 - gain_next;
				end
				OP_MUL_KS: prod_q <= prod;
				OP_MUL_IX: begin
					// gain * sample, scaled from Q1.30 times integer to Q12.16
					acc_q  <= prod_q[FracW+SampleW-1:FracW+SampleW-EstW];
					prod_q <= prod;
				end
				OP_MUL_IP: begin
					acc_q  <= acc_sum[EstW] ? {EstW{1'b1}} : acc_sum[EstW-1:0];
					prod_q <= prod;
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.acc      = acc_q;

endmodule

### rtl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: configuration, sequencer and result register.
//
//  channel     dir  handshake            payload
//  sample_ch   in   valid / ready        sample[11:0]
//  result_ch   out  valid / ready        estimate_fixed[27:0], estimate_whole[11:0]
//  cfg         in   cfg_we               cfg_index[1:0], cfg_data[31:0]
//
// A result becomes valid once its accepted item has passed the add step, the
// denominator step, the steps of the restoring gain divider, the gain step and
// the gain-times-sample, inverse-times-estimate and inverse-times-variance steps
// that share one multiplier, and then write-back.
// A new item is taken the cycle after write-back, while the last result still waits.
// Reset loads the configuration registers and the filter state with their defaults at once.
// A stalled result holds the sequencer at write-back until the register frees up.
module scalar_kalman_filter
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	skf_sample_if.sink         sample_ch,
	skf_result_if.source       result_ch,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [VarW-1:0]    cfg_data
);

	logic [VarW-1:0] process_noise_q;
	logic [VarW-1:0] measurement_noise_q;
	logic [VarW-1:0] initial_variance_q;
	logic [EstW-1:0] initial_estimate_q;

	step_t           step_q;
	ctrl_word_t      cw;
	logic            out_valid_q;
	logic [EstW-1:0] out_est_q;
	logic            out_free;
	logic            fire;
	logic            jump;
	dp_ctrl_t        dp_ctrl;
	dp_cfg_t         dp_cfg;
	dp_stat_t        dp_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q     <= ProcessNoiseRst;
			measurement_noise_q <= MeasurementNoiseRst;
			initial_variance_q  <= InitialVarianceRst;
			initial_estimate_q  <= InitialEstimateRst;
		end else if (cfg_we) begin
			case (cfg_index)
				RegProcessNoise:     process_noise_q     <= cfg_data;
				RegMeasurementNoise: measurement_noise_q <= cfg_data;
				RegInitialVariance:  initial_variance_q  <= cfg_data;
				RegInitialEstimate:  initial_estimate_q  <= cfg_data[EstW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Preload state together with a write to an initial register
	assign dp_cfg.process_noise     = process_noise_q;
	assign dp_cfg.measurement_noise = measurement_noise_q;
	assign dp_cfg.load_p  = cfg_we && (cfg_index == RegInitialVariance);
	assign dp_cfg.p_value = cfg_data;
	assign dp_cfg.load_x  = cfg_we && (cfg_index == RegInitialEstimate);
	assign dp_cfg.x_value = cfg_data[EstW-1:0];

	// Decode the current control word and its gate
	assign cw       = ucode(step_q);
	assign out_free = !out_valid_q || result_ch.ready;

	always_comb begin
		case (cw.gate)
			GATE_IN:  fire = sample_ch.valid;
			GATE_OUT: fire = out_free;
			default:  fire = 1'b1;
		endcase
	end

	always_comb begin
		case (cw.cond)
			COND_ALWAYS: jump = 1'b1;
			COND_LOOP:   jump = !dp_stat.cnt_zero;
			default:     jump = 1'b0;
		endcase
	end

	assign dp_ctrl.op   = cw.op;
	assign dp_ctrl.fire = fire;

	// Step counter: hold while gated, advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (fire) begin
			step_q <= jump ? cw.target : step_t'(step_q + 4'd1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && cw.op == OP_WB) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cw.op == OP_WB) begin
			out_est_q <= dp_stat.acc;
		end
	end

	skf_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dp_ctrl),
		.cfg    (dp_cfg),
		.sample (sample_ch.sample),
		.stat   (dp_stat)
	);

	assign sample_ch.ready          = (cw.gate == GATE_IN);
	assign result_ch.valid          = out_valid_q;
	assign result_ch.estimate_fixed = out_est_q;
	assign result_ch.estimate_whole = out_est_q[EstW-1:EstW-SampleW];

	// A result appears only out of the write-back step
	a_valid_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q) == ST_WB)
		else $error("result valid rose outside write-back");

	// An accepted item starts the program
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ch.valid && sample_ch.ready) |=> step_q == ST_ADDQ)
		else $error("accepted item did not start the sequence");

	// A blocked write-back holds its step
	a_wb_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_WB && !out_free) |=> step_q == ST_WB)
		else $error("write-back left while result register was full");

endmodule

### sim/skf_estimate_checker.sv
`timescale 1ns / 100ps
// Watches the sample, result and register ports, predicts each estimate and compares.
module skf_estimate_checker
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	skf_sample_if              sample_ch,
	skf_result_if              result_ch,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [VarW-1:0]    cfg_data,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 writes
);

	localparam logic [63:0] UnityGain = 64'd1 << FracW;
	localparam logic [63:0] VarMax    = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [EstW-1:0]    estimate_fixed;
		logic [SampleW-1:0] estimate_whole;
	} estimate_t;

	// Filter configuration and state as the block should hold them
	logic [VarW-1:0] process_var;
	logic [VarW-1:0] meas_var;
	logic [VarW-1:0] err_var;
	logic [EstW-1:0] level_est;

	estimate_t expected_estimates[$];
	estimate_t predicted;
	estimate_t observed;

	// Run one filter update on a sample and return the new estimate
	task automatic kalman_update(input logic [SampleW-1:0] z, output estimate_t est);
		logic [63:0] p_prior;
		logic [63:0] denom;
		logic [63:0] gain;
		logic [63:0] keep;
		logic [63:0] blend;
		logic [63:0] p_post;
		p_prior = 64'(err_var) + 64'(process_var);
		if (p_prior > VarMax)
			p_prior = VarMax;
		denom = p_prior + 64'(meas_var);
		gain  = (denom == 64'd0) ? 64'd0 : (p_prior << FracW) / denom;
		keep  = UnityGain - gain;
		blend = ((gain * (64'(z) << 16)) >> FracW) + ((keep * 64'(level_est)) >> FracW);
		p_post = (keep * p_prior) >> FracW;
		level_est = blend[EstW-1:0];
		err_var   = p_post[VarW-1:0];
		est.estimate_fixed = blend[EstW-1:0];
		est.estimate_whole = blend[EstW-1:16];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_var = ProcessNoiseRst;
			meas_var    = MeasurementNoiseRst;
			err_var     = InitialVarianceRst;
			level_est   = InitialEstimateRst;
			expected_estimates.delete();
			mismatches  = 0;
			checked     = 0;
			writes      = 0;
			pending     = 0;
		end else begin
			// Apply register writes; the initial values also preload the state
			if (cfg_we) begin
				writes++;
				case (cfg_index)
					RegProcessNoise:     process_var = cfg_data;
					RegMeasurementNoise: meas_var    = cfg_data;
					RegInitialVariance:  err_var     = cfg_data;
					RegInitialEstimate:  level_est   = cfg_data[EstW-1:0];
					default: ;
				endcase
			end
			// Predict the estimate for each accepted sample
			if (sample_ch.valid && sample_ch.ready) begin
				kalman_update(sample_ch.sample, predicted);
				expected_estimates.push_back(predicted);
			end
			// Compare each accepted result with the oldest prediction
			if (result_ch.valid && result_ch.ready) begin
				if (expected_estimates.size() == 0) begin
					$error("unexpected result: estimate_fixed 0x%07h estimate_whole 0x%03h",
						result_ch.estimate_fixed, result_ch.estimate_whole);
					mismatches++;
				end else begin
					observed = expected_estimates.pop_front();
					checked++;
					if (result_ch.estimate_fixed !== observed.estimate_fixed) begin
						$error("estimate_fixed: expected 0x%07h, got 0x%07h",
							observed.estimate_fixed, result_ch.estimate_fixed);
						mismatches++;
					end
					if (result_ch.estimate_whole !== observed.estimate_whole) begin
						$error("estimate_whole: expected 0x%03h, got 0x%03h",
							observed.estimate_whole, result_ch.estimate_whole);
						mismatches++;
					end
				end
			end
			pending = expected_estimates.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the scalar Kalman filter testbench: clock, reset, stimulus and verdict.
module tb;
	import skf_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int DrainCycles = 50;
	localparam int LongStall   = 300;
	localparam int SegItems    = 100;
	localparam int SegCount    = 5;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [VarW-1:0]    cfg_data;

	skf_sample_if sample_ch();
	skf_result_if result_ch();

	int mismatches;
	int pending;
	int checked;
	int writes;
	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int stall_request = 0;
	int samples_sent  = 0;
	int cycle_count   = 0;

	scalar_kalman_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	skf_estimate_checker estimate_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.result_ch  (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.writes     (writes)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("scalar_kalman_filter regression: fail");
		$finish;
	end

	// Drive result ready: random idling, plus long hold-offs on request
	initial begin : take_results
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	// Offer one sample after a random gap and hold it until accepted
	task automatic send_sample(input logic [SampleW-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= value;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// Stop offering and wait until every estimate is back and the block is quiet
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [VarW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Write all four registers, starting at a random one
	task automatic configure(input logic [VarW-1:0] q, input logic [VarW-1:0] r,
			input logic [VarW-1:0] p, input logic [VarW-1:0] x);
		logic [CfgIdxW-1:0] regs[4];
		logic [VarW-1:0]    vals[4];
		int                 first;
		regs  = '{RegProcessNoise, RegMeasurementNoise, RegInitialVariance,
			RegInitialEstimate};
		vals  = '{q, r, p, x};
		first = $urandom_range(3);
		for (int k = 0; k < 4; k++)
			write_reg(regs[(first + k) % 4], vals[(first + k) % 4]);
	endtask

	// Variance or noise value, weighted toward the extremes and small values
	function automatic logic [VarW-1:0] pick_variance();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2:       return $urandom_range(1 << 20);
			3:       return $urandom >> $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Starting estimate; upper bits of the write data are random too
	function automatic logic [VarW-1:0] pick_estimate();
		case ($urandom_range(4))
			0:       return {4'($urandom_range(15)), 28'h0000000};
			1:       return '1;
			2:       return {4'h0, 12'($urandom_range(4095)), 16'h0000};
			default: return $urandom;
		endcase
	endfunction

	// Noisy sample around a level, with occasional wild values and extremes
	function automatic logic [SampleW-1:0] next_sample(input int level);
		int v;
		case ($urandom_range(9))
			0:       return SampleW'($urandom);
			1:       return $urandom_range(1) ? '1 : '0;
			default: begin
				v = level + $urandom_range(64) - 32;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				return SampleW'(v);
			end
		endcase
	endfunction

	initial begin
		int level;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= RegProcessNoise;
		cfg_data         <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: field extremes and alternating bit patterns
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(12'h800);
		send_sample(12'h555);
		send_sample(12'hAAA);
		send_sample(12'hFFF);
		drain();

		// Variance saturates when the process noise is added
		configure('1, MeasurementNoiseRst, '1, 32'h0000_0000);
		send_sample(12'hFFF);
		send_sample(12'h000);
		drain();

		// Zero denominator: gain is zero, estimate holds at its maximum
		configure('0, '0, '0, '1);
		send_sample(12'h000);
		send_sample(12'hFFF);
		drain();

		// Zero denominator again, estimate held at zero
		write_reg(RegInitialEstimate, '0);
		send_sample(12'hFFF);
		drain();

		// All noise at maximum: gain near one half
		configure('1, '1, '1, {4'h0, 28'h8000000});
		send_sample(12'hFFF);
		send_sample(12'h000);
		drain();

		// No measurement noise: full gain on the first sample, zero gain after it
		configure('0, '0, 32'd1, 32'd12345);
		send_sample(12'hFFF);
		send_sample(12'h000);
		send_sample(12'h001);
		drain();

		// Random part over three idle mixes, reconfigured per segment
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 18;
					take_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					take_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SegCount; seg++) begin
				configure(pick_variance(), pick_variance(), pick_variance(), pick_estimate());
				if (seg == 1)
					stall_request = LongStall;
				level = $urandom_range(4095);
				for (int n = 0; n < SegItems; n++) begin
					// step the signal level now and then
					if (n % 25 == 0 && $urandom_range(1))
						level = $urandom_range(4095);
					send_sample(next_sample(level));
				end
				drain();
			end
		end

		$display("Sent %0d samples and checked %0d estimates across %0d register writes.",
			samples_sent, checked, writes);
		$display("Covered saturation, zero gain, full gain, three idle mixes and long stalls.");
		if (mismatches == 0 && pending == 0)
			$display("scalar_kalman_filter regression: pass");
		else
			$display("scalar_kalman_filter regression: fail");
		$finish;
	end

endmodule

### scalar_kalman_filter.f
rtl/skf_pkg.sv
rtl/skf_sample_if.sv
rtl/skf_result_if.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter.sv
sim/skf_estimate_checker.sv
sim/tb.sv
